### design/motor_speed_pd_controller_assert.svh
// ----------------------------------------------------------------------------
// motor speed pd controller assertion macros
// shared property forms for the controller checks
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PD_CONTROLLER_ASSERT_SVH
`define MOTOR_SPEED_PD_CONTROLLER_ASSERT_SVH

// condition must hold in the same cycle
`define MSPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define MSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mspd_pkg.sv
// ----------------------------------------------------------------------------
// mspd_pkg
// types and fixed constants of the motor speed pd controller
// ----------------------------------------------------------------------------
package mspd_pkg;

  // field widths
  localparam int SPEED_W   = 32;
  localparam int CNT_W     = 32;
  localparam int TGT_W     = 16;
  localparam int GAIN_W    = 10;
  localparam int DUTY_W    = 8;

  // serial divider: dividend width covers the speed scaling and the error numerator
  localparam int DIV_W     = 40;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int NUM_W     = DIV_W + 2;

  // serial multiplier operand width (speed sums carry one extra bit)
  localparam int MUL_A_W   = SPEED_W + 1;

  // filter coefficients as decimal fractions of COEF_DEN
  localparam int POLE_NUM  = 7285;
  localparam int ZERO_NUM  = 1358;
  localparam int COEF_DEN  = 10000;

  // count delta scaling: times 100 over 17
  localparam int SPEED_MUL = 100;
  localparam int SPEED_DIV = 17;

  localparam int DUTY_MAX  = 255;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 10'd200;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 1'b0,
    CFG_DERIV_GAIN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] encoder_count;
    logic signed [TGT_W-1:0] target_speed;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         forward_duty;
    logic [DUTY_W-1:0]         reverse_duty;
    logic signed [SPEED_W-1:0] filtered_speed;
  } out_t;

  // multiplier pass control
  typedef struct packed {
    logic start;
    logic accum;
  } mul_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SCALE,
    ST_SPD_WAIT,
    ST_RAW,
    ST_POLE_GO,
    ST_POLE_WAIT,
    ST_ZERO_GO,
    ST_ZERO_WAIT,
    ST_ROUND_ABS,
    ST_ROUND,
    ST_NUM,
    ST_ERR_GO,
    ST_ERR_WAIT,
    ST_ERR_SAT,
    ST_PROP_GO,
    ST_PROP_WAIT,
    ST_DERIV_GO,
    ST_DERIV_WAIT,
    ST_PULSE,
    ST_OUT
  } ctl_state_t;

endpackage

### design/mspd_div.sv
// ----------------------------------------------------------------------------
// mspd_div
// restoring divider, one quotient bit per cycle, narrow remainder path
// ----------------------------------------------------------------------------
module mspd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mspd_pkg::DIV_W-1:0]     dividend,
  input  logic [mspd_pkg::TGT_W-1:0]     divisor,
  output logic                           done,
  output logic [mspd_pkg::DIV_W-1:0]     quotient
);
  import mspd_pkg::*;

  logic [DIV_W-1:0]     quo;
  logic [TGT_W-1:0]     rem;
  logic [TGT_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [TGT_W:0]       trial;
  logic [TGT_W:0]       diff;
  logic                 fits;

  // one trial subtract per cycle
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? diff[TGT_W-1:0] : trial[TGT_W-1:0];
    end
  end

endmodule

### design/mspd_mul.sv
// ----------------------------------------------------------------------------
// mspd_mul
// shift-add multiplier, one multiplier bit per cycle, with accumulate
// ----------------------------------------------------------------------------
module mspd_mul #(
  parameter int BW = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mspd_pkg::mul_ctl_t                      ctl,
  input  logic signed [mspd_pkg::MUL_A_W-1:0]     a,
  input  logic [BW-1:0]                           b,
  output logic                                    done,
  output logic signed [mspd_pkg::MUL_A_W+BW:0]    acc
);
  import mspd_pkg::*;

  localparam int PW = MUL_A_W + BW;
  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      prod_next;
  logic signed [PW-1:0]      a_term;
  logic signed [MUL_A_W-1:0] a_reg;
  logic [BW-1:0]             b_reg;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic                      fin;
  logic                      accum;

  // msb-first horner step
  always_comb begin
    a_term    = b_reg[BW-1] ? PW'(a_reg) : '0;
    prod_next = (prod <<< 1) + a_term;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= CW'(BW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // partial product and accumulator
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
      accum <= ctl.accum;
    end else if (busy) begin
      prod  <= prod_next;
      b_reg <= b_reg << 1;
    end else if (fin) begin
      acc <= (accum ? acc : '0) + (PW + 1)'(prod);
    end
  end

endmodule

### design/motor_speed_pd_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_pd_controller
// Per control tick this block takes the absolute encoder count and the signed
// target speed and returns one result: forward and reverse pwm duty (one of
// them always 0) and the filtered speed in signed fixed point with FRAC_BITS
// fraction bits. The count delta is scaled by 100/17, run through a
// first-order low-pass filter, turned into a relative error against the
// target and fed to a pd law whose gains sit in two configuration registers.
// One request is worked on at a time: each tick runs two passes of the serial
// divider (speed scaling and error division) and four shift-add passes of the
// serial multiplier (two filter products and two gain products). With a zero
// target the error path is skipped. A finished result waits in the output
// register while the next request is already accepted.
// ----------------------------------------------------------------------------
module motor_speed_pd_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mspd_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mspd_pkg::out_t                   out_data,
  input  logic                             cfg_write_en,
  input  logic [mspd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mspd_pkg::GAIN_W-1:0]      cfg_data
);
  import mspd_pkg::*;

  localparam int ERR_W   = 8 + FRAC_BITS;
  localparam int MUL_B_W = (FRAC_BITS > GAIN_W) ? FRAC_BITS : GAIN_W;
  localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;

  localparam logic [63:0] POLE_FULL =
    ((64'(POLE_NUM) << FRAC_BITS) + 64'(COEF_DEN / 2)) / 64'(COEF_DEN);
  localparam logic [63:0] ZERO_FULL =
    ((64'(ZERO_NUM) << FRAC_BITS) + 64'(COEF_DEN / 2)) / 64'(COEF_DEN);
  localparam logic [MUL_B_W-1:0] COEF_POLE = POLE_FULL[MUL_B_W-1:0];
  localparam logic [MUL_B_W-1:0] COEF_ZERO = ZERO_FULL[MUL_B_W-1:0];

  localparam logic [CNT_W:0]   DELTA_LIM  = (CNT_W + 1)'(1) << (SPEED_W - FRAC_BITS);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [DIV_W-1:0] ERR_POS_LIM = DIV_W'((64'd1 << (ERR_W - 1)) - 64'd1);
  localparam logic [DIV_W-1:0] ERR_NEG_LIM = DIV_W'(64'd1 << (ERR_W - 1));
  localparam logic [ERR_W-1:0] ERR_MAX     = ERR_POS_LIM[ERR_W-1:0];
  localparam logic [ERR_W-1:0] ERR_MIN     = ERR_NEG_LIM[ERR_W-1:0];

  ctl_state_t state;
  ctl_state_t state_next;

  // configuration and loop state
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         deriv_gain;
  logic signed [CNT_W-1:0]   last_count;
  logic signed [SPEED_W-1:0] last_raw;
  logic signed [SPEED_W-1:0] last_y;
  logic signed [ERR_W-1:0]   last_err;

  // working registers of one request
  in_t                       item;
  logic [CNT_W:0]            dmag;
  logic                      raw_neg;
  logic signed [SPEED_W-1:0] raw;
  logic [ACC_W-1:0]          r_abs;
  logic                      r_neg;
  logic signed [SPEED_W-1:0] y;
  logic signed [NUM_W-1:0]   num;
  logic                      e_neg;
  logic signed [ERR_W-1:0]   err;
  logic [DUTY_W-1:0]         duty;

  // unit hookup
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend;
  logic [TGT_W-1:0]           div_divisor;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quo;
  mul_ctl_t                   mul_ctl;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic                       mul_done;
  logic signed [ACC_W-1:0]    mul_acc;

  logic in_accept;
  logic out_load;

  // combinational datapath terms
  logic signed [CNT_W:0]     delta;
  logic [CNT_W:0]            delta_neg;
  logic [CNT_W:0]            delta_mag;
  logic [CNT_W:0]            m_clamp;
  logic [DIV_W-1:0]          spd_dividend;
  logic [DIV_W-1:0]          q_neg;
  logic signed [SPEED_W-1:0] raw_sat;
  logic [ACC_W-1:0]          acc_neg;
  logic [ACC_W-1:0]          r_sum;
  logic [ACC_W-1:0]          r_mag;
  logic [ACC_W-1:0]          r_mag_neg;
  logic signed [SPEED_W-1:0] y_sat;
  logic [TGT_W-1:0]          t_abs;
  logic signed [NUM_W-1:0]   num_calc;
  logic [NUM_W-1:0]          num_abs;
  logic signed [ERR_W-1:0]   err_sat;
  logic signed [ERR_W:0]     e_diff;
  logic                      p_pos;
  logic [ACC_W-1:0]          p_int;
  logic [DUTY_W-1:0]         duty_calc;

  mspd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  mspd_mul #(
    .BW (MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .acc  (mul_acc)
  );

  // arithmetic between the serial passes
  always_comb begin
    // count delta, magnitude clamp, scale by 100 before the divide by 17
    delta        = {item.encoder_count[CNT_W-1], item.encoder_count}
                 - {last_count[CNT_W-1], last_count};
    delta_neg    = -delta;
    delta_mag    = delta[CNT_W] ? delta_neg : delta;
    m_clamp      = (dmag > DELTA_LIM) ? DELTA_LIM : dmag;
    spd_dividend = (DIV_W'(m_clamp) * DIV_W'(SPEED_MUL)) << FRAC_BITS;

    // raw speed saturation
    q_neg = -div_quo;
    if (raw_neg) begin
      raw_sat = (div_quo > DIV_W'(SPEED_MIN)) ? SPEED_MIN : q_neg[SPEED_W-1:0];
    end else begin
      raw_sat = (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPEED_W-1:0];
    end

    // filter rounding, ties away from zero
    acc_neg   = -mul_acc;
    r_sum     = r_abs + ROUND_HALF;
    r_mag     = r_sum >> FRAC_BITS;
    r_mag_neg = -r_mag;
    if (r_neg) begin
      y_sat = (r_mag > ACC_W'(SPEED_MIN)) ? SPEED_MIN : r_mag_neg[SPEED_W-1:0];
    end else begin
      y_sat = (r_mag > ACC_W'(SPEED_MAX)) ? SPEED_MAX : r_mag[SPEED_W-1:0];
    end

    // error numerator |target| * 2^f - y
    t_abs    = item.target_speed[TGT_W-1] ? TGT_W'(-item.target_speed)
                                          : item.target_speed;
    num_calc = NUM_W'(DIV_W'(t_abs) << FRAC_BITS) - NUM_W'(y);
    num_abs  = num[NUM_W-1] ? NUM_W'(-num) : num;

    // error saturation
    if (e_neg) begin
      err_sat = (div_quo > ERR_NEG_LIM) ? ERR_MIN : q_neg[ERR_W-1:0];
    end else begin
      err_sat = (div_quo > ERR_POS_LIM) ? ERR_MAX : div_quo[ERR_W-1:0];
    end
    e_diff = (ERR_W + 1)'(err) - (ERR_W + 1)'(last_err);

    // pulse truncation and clamp
    p_pos     = !mul_acc[ACC_W-1] && (mul_acc != '0);
    p_int     = mul_acc >> FRAC_BITS;
    duty_calc = '0;
    if (p_pos) begin
      duty_calc = (p_int > ACC_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : p_int[DUTY_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_valid) state_next = ST_DELTA;
      ST_DELTA:      state_next = ST_SCALE;
      ST_SCALE:      state_next = ST_SPD_WAIT;
      ST_SPD_WAIT:   if (div_done) state_next = ST_RAW;
      ST_RAW:        state_next = ST_POLE_GO;
      ST_POLE_GO:    state_next = ST_POLE_WAIT;
      ST_POLE_WAIT:  if (mul_done) state_next = ST_ZERO_GO;
      ST_ZERO_GO:    state_next = ST_ZERO_WAIT;
      ST_ZERO_WAIT:  if (mul_done) state_next = ST_ROUND_ABS;
      ST_ROUND_ABS:  state_next = ST_ROUND;
      ST_ROUND: begin
        state_next = (item.target_speed == '0) ? ST_OUT : ST_NUM;
      end
      ST_NUM:        state_next = ST_ERR_GO;
      ST_ERR_GO:     state_next = ST_ERR_WAIT;
      ST_ERR_WAIT:   if (div_done) state_next = ST_ERR_SAT;
      ST_ERR_SAT:    state_next = ST_PROP_GO;
      ST_PROP_GO:    state_next = ST_PROP_WAIT;
      ST_PROP_WAIT:  if (mul_done) state_next = ST_DERIV_GO;
      ST_DERIV_GO:   state_next = ST_DERIV_WAIT;
      ST_DERIV_WAIT: if (mul_done) state_next = ST_PULSE;
      ST_PULSE:      state_next = ST_OUT;
      ST_OUT:        if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = (state != ST_IDLE);
    out_load     = (state == ST_OUT) && (!out_valid || !out_stall);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_ctl      = '0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_SCALE: begin
        div_start    = 1'b1;
        div_dividend = spd_dividend;
        div_divisor  = TGT_W'(SPEED_DIV);
      end
      ST_ERR_GO: begin
        div_start    = 1'b1;
        div_dividend = num_abs[DIV_W-1:0];
        div_divisor  = t_abs;
      end
      ST_POLE_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = MUL_A_W'(last_y);
        mul_b         = COEF_POLE;
      end
      ST_ZERO_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.accum = 1'b1;
        mul_a         = MUL_A_W'(raw) + MUL_A_W'(last_raw);
        mul_b         = COEF_ZERO;
      end
      ST_PROP_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = MUL_A_W'(err);
        mul_b         = MUL_B_W'(prop_gain);
      end
      ST_DERIV_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.accum = 1'b1;
        mul_a         = MUL_A_W'(e_diff);
        mul_b         = MUL_B_W'(deriv_gain);
      end
      default: ;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // state, configuration, loop memory and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prop_gain  <= PROP_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      last_count <= '0;
      last_raw   <= '0;
      last_y     <= '0;
      last_err   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PROP_GAIN:  prop_gain  <= cfg_data;
          CFG_DERIV_GAIN: deriv_gain <= cfg_data;
        endcase
      end
      if (out_load) begin
        last_count <= item.encoder_count;
        last_raw   <= raw;
        last_y     <= y;
        last_err   <= err;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_accept) item <= in_data;
    case (state)
      ST_DELTA: begin
        dmag    <= delta_mag;
        raw_neg <= delta[CNT_W] ^ item.target_speed[TGT_W-1];
      end
      ST_RAW: raw <= raw_sat;
      ST_ROUND_ABS: begin
        r_abs <= mul_acc[ACC_W-1] ? acc_neg : mul_acc;
        r_neg <= mul_acc[ACC_W-1];
      end
      ST_ROUND: begin
        y    <= y_sat;
        err  <= '0;
        duty <= '0;
      end
      ST_NUM:     num   <= num_calc;
      ST_ERR_GO:  e_neg <= num[NUM_W-1];
      ST_ERR_SAT: err   <= err_sat;
      ST_PULSE:   duty  <= duty_calc;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.forward_duty   <= item.target_speed[TGT_W-1] ? '0 : duty;
      out_data.reverse_duty   <= item.target_speed[TGT_W-1] ? duty : '0;
      out_data.filtered_speed <= y;
    end
  end

  // checks
  `include "motor_speed_pd_controller_assert.svh"

  `MSPD_ASSERT_NOW(a_one_side_drive, out_valid, (out_data.forward_duty == '0) || (out_data.reverse_duty == '0), "both drive channels active")
  `MSPD_ASSERT_NOW(a_div_done_seq, div_done, (state == ST_SPD_WAIT) || (state == ST_ERR_WAIT), "divider finished outside a divide wait")
  `MSPD_ASSERT_NOW(a_mul_done_seq, mul_done, (state == ST_POLE_WAIT) || (state == ST_ZERO_WAIT) || (state == ST_PROP_WAIT) || (state == ST_DERIV_WAIT), "multiplier finished outside a multiply wait")
  `MSPD_ASSERT_NEXT(a_filter_commit, out_load, out_valid && (last_y == out_data.filtered_speed), "filter state and result disagree")

endmodule
